### rtl/c420rgb_pkg.sv
// ----------------------------------------------------------------------------
// c420rgb_pkg
// Shared types, constants and helpers for the 4:2:0 chroma to RGB converter.
// ----------------------------------------------------------------------------
package c420rgb_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int WIDTH_W    = 12;
   localparam int COL_W      = 11;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;
   localparam int PROD_W     = 27;
   localparam int SUM_W      = 28;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

   // Q16 coefficients
   localparam logic signed [17:0] COEF_R_PR = 18'sd91881;
   localparam logic signed [17:0] COEF_G_PB = 18'sd22553;
   localparam logic signed [17:0] COEF_G_PR = 18'sd46802;
   localparam logic signed [17:0] COEF_B_PB = 18'sd116130;
   localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;

   typedef enum logic [1:0] {
      PH_LUMA = 2'd0,
      PH_BLUE = 2'd1,
      PH_RED  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
   } pixel_type;

   // floor(v / 65536) clamped to 0..255
   function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] v);
      logic [7:0] res;
      if (v[SUM_W-1])
         res = 8'd0;
      else if (|v[SUM_W-2:24])
         res = 8'hff;
      else
         res = v[23:16];
      return res;
   endfunction

   function automatic logic signed [8:0] center(input logic [7:0] c);
      return $signed({1'b0, c}) - CHROMA_OFS;
   endfunction

endpackage

### rtl/chroma_420_to_rgb_core.sv
// ----------------------------------------------------------------------------
// chroma_420_to_rgb_core
// 4:2:0 byte stream to full-range BT.601 RGB, chroma kept in a line buffer.
// ----------------------------------------------------------------------------
// A pixel's last byte passes stage 1 and stage 2 into the result queue.
// One byte per cycle unless stalled; at most one line-buffer access per beat.
// Input stalls once queued plus in-flight pixels reach the 8-entry queue depth.
// Reset: counters, phase and queue cleared, image_width back to 640.
// The chroma line buffer is not cleared; entries are valid once written.
module chroma_420_to_rgb_core
   import c420rgb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tuser,   // [0] frame_start
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic                rsp_tlast,   // row_end
   input  logic                csr_we,
   input  logic [WIDTH_W-1:0]  csr_wdata    // image_width
);

   // ---------------- configuration ----------------
   logic [WIDTH_W-1:0] width_ff;

   always_ff @(posedge clock) begin
      if (reset)
         width_ff <= WIDTH_RESET;
      else if (csr_we)
         width_ff <= csr_wdata;
   end

   // ---------------- front end state ----------------
   phase_type          phase_ff, phase_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               odd_ff, odd_in;
   logic [7:0]         luma_ff, luma_in;
   logic [7:0]         blue_ff, blue_in;

   logic [WIDTH_W-1:0] width_eff;
   logic [COL_W-1:0]   col_eff;
   logic               odd_eff;
   phase_type          phase_eff;
   logic               accept;
   logic               produce;
   logic               line_we;
   logic               use_line;
   logic               last_pix;
   logic [LINE_AW-1:0] line_idx;
   logic [7:0]         s0_y, s0_cb, s0_cr;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      width_eff = width_ff;
      if (width_ff == '0)
         width_eff = WIDTH_W'(1);
      else if (width_ff > WIDTH_MAX)
         width_eff = WIDTH_MAX;

      col_eff   = col_ff;
      odd_eff   = odd_ff;
      phase_eff = phase_ff;
      if (req_tuser) begin
         col_eff   = '0;
         odd_eff   = 1'b0;
         phase_eff = PH_LUMA;
      end
      if ({1'b0, col_eff} >= width_eff)
         col_eff = '0;

      line_idx = col_eff[COL_W-1:1];
      last_pix = ({1'b0, col_eff} + WIDTH_W'(1)) >= width_eff;

      phase_in = phase_eff;
      luma_in  = luma_ff;
      blue_in  = blue_ff;
      produce  = 1'b0;
      line_we  = 1'b0;
      use_line = 1'b0;
      s0_y     = luma_ff;
      s0_cb    = blue_ff;
      s0_cr    = req_tdata;

      if (!odd_eff && !col_eff[0]) begin
         case (phase_eff)
            PH_LUMA: begin
               luma_in  = req_tdata;
               phase_in = PH_BLUE;
            end
            PH_BLUE: begin
               blue_in  = req_tdata;
               phase_in = PH_RED;
            end
            PH_RED: begin
               line_we  = 1'b1;
               produce  = 1'b1;
               phase_in = PH_LUMA;
            end
            default: begin
               luma_in  = req_tdata;
               phase_in = PH_BLUE;
            end
         endcase
      end else begin
         s0_y     = req_tdata;
         use_line = 1'b1;
         produce  = 1'b1;
         phase_in = PH_LUMA;
      end

      col_in = col_eff;
      odd_in = odd_eff;
      if (produce) begin
         if (last_pix) begin
            col_in = '0;
            odd_in = !odd_eff;
         end else begin
            col_in = col_eff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LUMA;
         col_ff   <= '0;
         odd_ff   <= 1'b0;
         luma_ff  <= '0;
         blue_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         odd_ff   <= odd_in;
         luma_ff  <= luma_in;
         blue_ff  <= blue_in;
      end
   end

   // ---------------- chroma line buffer ----------------
   logic [15:0] line_mem [LINE_DEPTH];
   logic [15:0] line_rd_ff;

   always_ff @(posedge clock) begin
      if (accept && line_we)
         line_mem[line_idx] <= {blue_ff, req_tdata};
      line_rd_ff <= line_mem[line_idx];
   end

   // ---------------- stage 1: chroma fetch ----------------
   logic       v1_ff;
   logic       use1_ff, last1_ff;
   logic [7:0] y1_ff, cb1_ff, cr1_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v1_ff <= 1'b0;
      else
         v1_ff <= accept && produce;
   end

   always_ff @(posedge clock) begin
      use1_ff  <= use_line;
      last1_ff <= last_pix;
      y1_ff    <= s0_y;
      cb1_ff   <= s0_cb;
      cr1_ff   <= s0_cr;
   end

   // ---------------- stage 2: products ----------------
   logic [7:0]               cb1, cr1;
   logic signed [8:0]        pb1, pr1;
   logic                     v2_ff, last2_ff;
   logic [7:0]               y2_ff;
   logic signed [PROD_W-1:0] r_pr_ff, g_pb_ff, g_pr_ff, b_pb_ff;

   assign cb1 = use1_ff ? line_rd_ff[15:8] : cb1_ff;
   assign cr1 = use1_ff ? line_rd_ff[7:0]  : cr1_ff;
   assign pb1 = center(cb1);
   assign pr1 = center(cr1);

   always_ff @(posedge clock) begin
      if (reset)
         v2_ff <= 1'b0;
      else
         v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      last2_ff <= last1_ff;
      y2_ff    <= y1_ff;
      r_pr_ff  <= PROD_W'(pr1) * PROD_W'(COEF_R_PR);
      g_pb_ff  <= PROD_W'(pb1) * PROD_W'(COEF_G_PB);
      g_pr_ff  <= PROD_W'(pr1) * PROD_W'(COEF_G_PR);
      b_pb_ff  <= PROD_W'(pb1) * PROD_W'(COEF_B_PB);
   end

   // ---------------- sums and clamp ----------------
   logic signed [SUM_W-1:0] base2, r_sum, g_sum, b_sum;
   pixel_type               pix2;

   always_comb begin
      base2 = $signed({4'd0, y2_ff, 16'd0});
      r_sum = base2 + SUM_W'(r_pr_ff);
      g_sum = base2 - SUM_W'(g_pb_ff) - SUM_W'(g_pr_ff);
      b_sum = base2 + SUM_W'(b_pb_ff);
      pix2.red     = clamp_q16(r_sum);
      pix2.green   = clamp_q16(g_sum);
      pix2.blue    = clamp_q16(b_sum);
      pix2.row_end = last2_ff;
   end

   // ---------------- result queue ----------------
   pixel_type          fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0] cnt_ff, cnt_in;
   logic [FIFO_CW-1:0] occupancy;
   logic               fifo_pop;
   pixel_type          head;

   assign fifo_pop  = rsp_tvalid && rsp_tready;
   assign occupancy = cnt_ff + FIFO_CW'(v1_ff) + FIFO_CW'(v2_ff);
   assign req_tready = !reset && (occupancy < FIFO_CW'(FIFO_DEPTH));

   always_comb begin
      cnt_in = cnt_ff;
      if (v2_ff && !fifo_pop)
         cnt_in = cnt_ff + FIFO_CW'(1);
      else if (!v2_ff && fifo_pop)
         cnt_in = cnt_ff - FIFO_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (v2_ff)
         fifo_mem[wr_ptr_ff] <= pix2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (v2_ff)
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (fifo_pop)
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         cnt_ff <= cnt_in;
      end
   end

   assign head       = fifo_mem[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {head.blue, head.green, head.red};
   assign rsp_tlast  = head.row_end;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= FIFO_CW'(FIFO_DEPTH))
      else $error("results in flight exceed queue room");

   a_phase_even: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_LUMA |-> !odd_ff && !col_ff[0])
      else $error("chroma phase active outside an even-row even-column pixel");

   a_write_emits: assert property (@(posedge clock) disable iff (reset)
      accept && line_we |=> v1_ff && !use1_ff)
      else $error("line buffer write without a pixel result");
`endif

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chroma_420_to_rgb_core. A behavioral decoder tracks
// the byte phase, column, row parity and chroma line, and predicts every RGB
// pixel. Each output beat is compared field by field with the oldest
// prediction. Directed tasks cover color extremes, width limits, lowering
// the width mid-row and frame restarts, then random frames run with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import c420rgb_pkg::*;

   localparam longint K_R_PR = 91881;
   localparam longint K_G_PB = 22553;
   localparam longint K_G_PR = 46802;
   localparam longint K_B_PB = 116130;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;   // [7:0] data_byte
   logic                req_tuser  = 1'b0; // [0] frame_start
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;         // [7:0] red, [15:8] green, [23:16] blue
   logic                rsp_tlast;         // row_end
   logic                csr_we     = 1'b0;
   logic [WIDTH_W-1:0]  csr_wdata  = '0;   // image_width

   // decoder state
   logic [WIDTH_W-1:0]  cfg_width    = WIDTH_RESET;
   phase_type           dec_phase    = PH_LUMA;
   logic [7:0]          dec_luma     = '0;
   logic [7:0]          dec_cb       = '0;
   int unsigned         dec_col      = 0;
   bit                  dec_odd_row  = 1'b0;
   logic [15:0]         line_chroma  [LINE_DEPTH];
   bit                  line_written [LINE_DEPTH];

   pixel_type           expected_pixels [$];
   int unsigned         bytes_sent = 0;
   int unsigned         fail_count = 0;
   bit                  steady     = 1'b0;

   chroma_420_to_rgb_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 30);
   end

   function automatic logic [7:0] sat_q16(input longint v);
      if (v < 0)
         return 8'd0;
      if ((v >>> 16) > 255)
         return 8'hff;
      return 8'(v >>> 16);
   endfunction

   function automatic pixel_type to_rgb(input logic [7:0] y, input logic [7:0] cb,
                                        input logic [7:0] cr);
      longint    base;
      longint    pb;
      longint    pr;
      pixel_type px;
      base = longint'(y) * 65536;
      pb = longint'(cb) - 128;
      pr = longint'(cr) - 128;
      px.red = sat_q16(base + K_R_PR * pr);
      px.green = sat_q16(base - K_G_PB * pb - K_G_PR * pr);
      px.blue = sat_q16(base + K_B_PB * pb);
      px.row_end = 1'b0;
      return px;
   endfunction

   function automatic int unsigned eff_width();
      if (cfg_width == 0)
         return 1;
      if (cfg_width > MAX_WIDTH)
         return MAX_WIDTH;
      return cfg_width;
   endfunction

   // true when the next byte without a frame start would read a chroma entry never written
   function automatic bit needs_restart();
      int unsigned col;
      col = (dec_col >= eff_width()) ? 0 : dec_col;
      if (!dec_odd_row && col[0] == 1'b0)
         return 1'b0;
      return !line_written[col >> 1];
   endfunction

   task automatic decode_byte(input logic [7:0] b, input bit fs);
      int unsigned w;
      int unsigned idx;
      bit          full_pixel;
      logic [7:0]  luma;
      logic [15:0] entry;
      pixel_type   px;
      w = eff_width();
      if (fs) begin
         dec_phase = PH_LUMA;
         dec_col = 0;
         dec_odd_row = 1'b0;
      end
      if (dec_col >= w)
         dec_col = 0;   // width lowered under a stale column
      idx = dec_col >> 1;
      full_pixel = !dec_odd_row && dec_col[0] == 1'b0;
      if (full_pixel && dec_phase == PH_LUMA) begin
         dec_luma = b;
         dec_phase = PH_BLUE;
      end else if (full_pixel && dec_phase == PH_BLUE) begin
         dec_cb = b;
         dec_phase = PH_RED;
      end else begin
         if (full_pixel) begin
            entry = {dec_cb, b};
            line_chroma[idx] = entry;
            line_written[idx] = 1'b1;
            luma = dec_luma;
         end else begin
            entry = line_chroma[idx];
            luma = b;
         end
         dec_phase = PH_LUMA;
         px = to_rgb(luma, entry[15:8], entry[7:0]);
         px.row_end = (dec_col + 1 >= w);
         if (px.row_end) begin
            dec_col = 0;
            dec_odd_row = !dec_odd_row;
         end else begin
            dec_col++;
         end
         expected_pixels = {expected_pixels, px};
      end
   endtask

   // entered and left at a falling edge; valid stays high after the beat
   task automatic send_byte(input logic [7:0] b, input bit fs);
      bit start;
      start = fs || needs_restart();
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, start);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                             input bit fs);
      send_byte(y, fs);
      if (dec_phase == PH_BLUE) begin
         send_byte(cb, 1'b0);
         send_byte(cr, 1'b0);
      end
   endtask

   task automatic hold_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] w);
      hold_for_results();
      repeat (8) @(negedge clock);   // beats that end no pixel may still be in flight
      csr_we <= 1'b1;
      csr_wdata <= w;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_width = w;
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_row_run(input int unsigned pixels, input bit fs);
      for (int unsigned i = 0; i < pixels; i++)
         send_pixel(rand_byte(), rand_byte(), rand_byte(), fs && i == 0);
   endtask

   task automatic test_default_width();
      send_row_run(8, 1'b1);
      send_row_run(3, 1'b0);
   endtask

   task automatic test_color_extremes();
      write_width(WIDTH_W'(4));
      send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
      send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
      send_pixel(8'd128, 8'd0,   8'd0,   1'b0);
      send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
   endtask

   task automatic test_width_limits();
      write_width('0);   // taken as one pixel per row
      send_pixel(8'd200, 8'd10, 8'd240, 1'b1);
      send_pixel(8'd50, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
      write_width(WIDTH_W'(1));
      send_row_run(3, 1'b1);
      write_width(WIDTH_MAX);
      send_row_run(3, 1'b1);
      write_width('1);   // clamps to the widest row
      send_row_run(3, 1'b1);
      send_row_run(2, 1'b0);
   endtask

   task automatic test_stale_column();
      write_width(WIDTH_W'(8));
      send_row_run(6, 1'b1);
      write_width(WIDTH_W'(3));   // column 6 now beyond the row, wraps to 0
      send_row_run(3, 1'b0);
      send_row_run(3, 1'b0);
   endtask

   task automatic test_restart_mid_pixel();
      send_byte(8'd90, 1'b1);
      send_byte(8'd30, 1'b0);
      send_byte(8'd170, 1'b1);   // restart after Cb, before Cr
      send_byte(8'd220, 1'b0);
      send_byte(8'd15, 1'b0);
      send_row_run(2, 1'b0);
      send_byte(8'd5, 1'b1);     // luma; the next byte restarts right after it
      send_byte(8'd77, 1'b1);
      send_byte(8'd140, 1'b0);
      send_byte(8'd60, 1'b0);
   endtask

   function automatic logic [WIDTH_W-1:0] pick_width();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 4)
         return '0;
      if (r < 7)
         return WIDTH_W'($urandom_range(200, 41));
      if (r < 15)
         return WIDTH_W'($urandom_range(40, 13));
      return WIDTH_W'($urandom_range(12, 1));
   endfunction

   task automatic send_frame();
      int unsigned w;
      int unsigned rows;
      int unsigned budget;
      w = eff_width();
      rows = (w > 40) ? 2 : $urandom_range(4, 1);
      budget = rows * w;
      if ($urandom_range(9) == 0)
         budget = $urandom_range(budget);   // cut short
      for (int unsigned i = 0; i < budget; i++) begin
         if ($urandom_range(59) == 0)
            send_byte(rand_byte(), 1'($urandom));   // misaligning beat
         send_pixel(rand_byte(), rand_byte(), rand_byte(),
                    i == 0 || $urandom_range(149) == 0);
      end
   endtask

   task automatic test_random_frames();
      int unsigned first;
      bit          paused;
      first = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - first < 1440) begin
         steady = (bytes_sent - first >= 500) && (bytes_sent - first < 850);
         if ($urandom_range(3) == 0)
            write_width(pick_width());
         send_frame();
         if (!paused && bytes_sent - first >= 1000) begin
            hold_for_results();
            paused = 1'b1;
         end
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected pixel beat: data %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                rsp_tdata[23:16] !== want.blue || rsp_tlast !== want.row_end) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("pixel mismatch: exp r %0d g %0d b %0d last %b, got r %0d g %0d b %0d last %b",
                           want.red, want.green, want.blue, want.row_end,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
            end
         end
      end
   end

   initial begin
      int unsigned wait_cycles;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_width();
      test_color_extremes();
      test_width_limits();
      test_stale_column();
      test_restart_mid_pixel();
      test_random_frames();
      req_tvalid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 5000 && expected_pixels.size() != 0; wait_cycles++)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (expected_pixels.size() != 0)
         $display("%0d expected pixels never arrived", expected_pixels.size());
      if (fail_count == 0 && expected_pixels.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin
      #6000000;
      $display("tb failed");
      $finish;
   end

endmodule
